// ===== rtl/core/sd_spi_r1_response_receiver_macros.svh =====
// Assertion helpers for the R1 response receiver.
`ifndef SD_SPI_R1_RESPONSE_RECEIVER_MACROS_SVH
`define SD_SPI_R1_RESPONSE_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define SDR1_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sdr1 assertion failed");
`define SDR1_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sdr1 assertion failed");
`else
`define SDR1_ASSERT(lbl, clk, rstn, prop)
`define SDR1_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/sdr1_pkg.sv =====
package sdr1_pkg;

  typedef struct packed {
    logic        command;
    logic [7:0]  rx_byte;
    logic [10:0] response_length;
  } sdr1_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] byte_out;
    logic [1:0] byte_kind;
    logic       last;
  } sdr1_rsp_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_R1     = 5'b00010,
    PH_TOKEN  = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_SETTLE = 5'b10000
  } sdr1_phase_e;

  localparam logic        CMD_ARM       = 1'b0;

  localparam logic [2:0]  ST_BUSY       = 3'd0;
  localparam logic [2:0]  ST_OK         = 3'd1;
  localparam logic [2:0]  ST_TIMEOUT    = 3'd2;
  localparam logic [2:0]  ST_TOKEN      = 3'd3;
  localparam logic [2:0]  ST_NOT_IDLE   = 3'd4;

  localparam logic [1:0]  KIND_NONE     = 2'd0;
  localparam logic [1:0]  KIND_R1       = 2'd1;
  localparam logic [1:0]  KIND_DATA     = 2'd2;

  localparam logic [7:0]  TOKEN_START   = 8'hFE;
  localparam logic [7:0]  IDLE_BYTE     = 8'hFF;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

endpackage

// ===== rtl/core/sd_spi_r1_response_receiver.sv =====
// A request is registered in sdr1_in_stage, then its result is registered in sdr1_out_stage.
// One request per cycle while out_ready_i allows; each byte is one phase update in sdr1_fsm.
// With both stages full, in_ready_o follows out_ready_i combinationally.
// Reset (rst_ni low, async): not armed, response_timeout 1000, both stages empty.
`include "sd_spi_r1_response_receiver_macros.svh"

module sd_spi_r1_response_receiver import sdr1_pkg::*; #(
  parameter int MAX_LENGTH = 1024,
  parameter int IDLE_LIMIT = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sdr1_req_t   in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sdr1_rsp_t   out_rsp_o
);

  logic      stage_valid;
  sdr1_req_t stage_req;
  logic      out_free;
  logic      step;
  sdr1_rsp_t step_rsp;

  assign step = stage_valid && out_free;

  sdr1_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .take_i     (step),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  sdr1_fsm #(
    .MAX_LENGTH (MAX_LENGTH),
    .IDLE_LIMIT (IDLE_LIMIT)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .req_i       (stage_req),
    .rsp_o       (step_rsp)
  );

  sdr1_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .rsp_i       (step_rsp),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  `SDR1_ASSERT(a_last_has_status, clk_i, rst_ni,
               (out_valid_o && out_rsp_o.last) |-> (out_rsp_o.status != ST_BUSY))
  `SDR1_ASSERT(a_byte_not_final, clk_i, rst_ni,
               (out_valid_o && out_rsp_o.byte_kind != KIND_NONE) |->
               (!out_rsp_o.last && out_rsp_o.status == ST_BUSY))
  `SDR1_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, in_valid_i && in_ready_o, stage_valid)
  `SDR1_ASSERT_NEXT(a_step_fills_out, clk_i, rst_ni, step, out_valid_o)

endmodule

// ===== rtl/core/sdr1_in_stage.sv =====
module sdr1_in_stage import sdr1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sdr1_req_t in_req_i,
  input  logic      take_i,
  output logic      valid_o,
  output sdr1_req_t req_o
);

  logic      valid_q, valid_d;
  sdr1_req_t req_q;
  logic      accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== rtl/core/sdr1_fsm.sv =====
module sdr1_fsm import sdr1_pkg::*; #(
  parameter int MAX_LENGTH = 1024,
  parameter int IDLE_LIMIT = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  sdr1_req_t   req_i,
  output sdr1_rsp_t   rsp_o
);

  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int IW = $clog2(IDLE_LIMIT + 1);

  sdr1_phase_e   phase_q, phase_d;
  logic [16:0]   wait_q, wait_d;
  logic [IW-1:0] idle_q, idle_d;
  logic [LW-1:0] left_q, left_d;
  logic [LW-1:0] len_q, len_d;
  logic          wants_q, wants_d;
  logic [15:0]   timeout_q;

  logic [16:0]   wait_inc;
  logic          wait_over;
  logic [IW-1:0] idle_inc;
  logic [LW-1:0] len_sat;
  logic [LW-1:0] left_dec;
  sdr1_rsp_t     rsp;

  assign wait_inc  = wait_q + 17'd1;
  assign wait_over = wait_inc > {1'b0, timeout_q};
  assign idle_inc  = idle_q + IW'(1);
  assign len_sat   = (32'(req_i.response_length) > MAX_LENGTH) ?
                     LW'(MAX_LENGTH) : LW'(req_i.response_length);
  assign left_dec  = (left_q != '0) ? left_q - LW'(1) : left_q;

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    idle_d  = idle_q;
    left_d  = left_q;
    len_d   = len_q;
    wants_d = wants_q;
    rsp     = '{status: ST_BUSY, byte_out: 8'h00, byte_kind: KIND_NONE, last: 1'b0};

    if (req_i.command == CMD_ARM) begin
      len_d   = len_sat;
      wants_d = (len_sat != '0);
      left_d  = '0;
      wait_d  = '0;
      idle_d  = '0;
      phase_d = PH_R1;
    end else begin
      case (phase_q)
        PH_R1: begin
          if (!req_i.rx_byte[7]) begin
            if (wants_q) begin
              phase_d = PH_TOKEN;
              wait_d  = '0;
            end else begin
              phase_d = PH_SETTLE;
              idle_d  = '0;
            end
            rsp.byte_out  = req_i.rx_byte;
            rsp.byte_kind = KIND_R1;
          end else begin
            wait_d = wait_inc;
            if (wait_over) begin
              phase_d    = PH_IDLE;
              rsp.status = ST_TIMEOUT;
              rsp.last   = 1'b1;
            end
          end
        end
        PH_TOKEN: begin
          if (req_i.rx_byte == TOKEN_START) begin
            left_d = len_q - LW'(1);
            if (len_q == LW'(1)) begin
              phase_d = PH_SETTLE;
              idle_d  = '0;
            end else begin
              phase_d = PH_DATA;
            end
          end else if (req_i.rx_byte == IDLE_BYTE) begin
            wait_d = wait_inc;
            if (wait_over) begin
              phase_d    = PH_IDLE;
              rsp.status = ST_TIMEOUT;
              rsp.last   = 1'b1;
            end
          end else begin
            phase_d    = PH_IDLE;
            rsp.status = ST_TOKEN;
            rsp.last   = 1'b1;
          end
        end
        PH_DATA: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_SETTLE;
            idle_d  = '0;
          end
          rsp.byte_out  = req_i.rx_byte;
          rsp.byte_kind = KIND_DATA;
        end
        PH_SETTLE: begin
          idle_d = idle_inc;
          if (req_i.rx_byte == IDLE_BYTE) begin
            phase_d    = PH_IDLE;
            rsp.status = ST_OK;
            rsp.last   = 1'b1;
          end else if (idle_inc >= IW'(IDLE_LIMIT)) begin
            phase_d    = PH_IDLE;
            rsp.status = ST_NOT_IDLE;
            rsp.last   = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      wait_q    <= '0;
      idle_q    <= '0;
      left_q    <= '0;
      len_q     <= '0;
      wants_q   <= 1'b0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        wait_q  <= wait_d;
        idle_q  <= idle_d;
        left_q  <= left_d;
        len_q   <= len_d;
        wants_q <= wants_d;
      end
    end
  end

  assign rsp_o = rsp;

endmodule

// ===== rtl/core/sdr1_out_stage.sv =====
module sdr1_out_stage import sdr1_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  sdr1_rsp_t rsp_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sdr1_rsp_t out_rsp_o
);

  logic      valid_q, valid_d;
  sdr1_rsp_t rsp_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
